// File: hw/rtl/sjt_pkg.sv
// ----------------------------------------------------------------------------
// sjt_pkg: shared types and constants of the sorted junction table
// Entry layout, cell commands, action and status codes, and sizing constants.
// ----------------------------------------------------------------------------
package sjt_pkg;

    localparam int CAPACITY       = 256;
    localparam int POSITION_BITS  = 32;
    localparam int IDX_W          = $clog2(CAPACITY);
    localparam int CNT_W          = $clog2(CAPACITY + 1);
    localparam int RANK_W         = 8;
    localparam int SEL_W          = (IDX_W > RANK_W) ? IDX_W : RANK_W;
    localparam int GRP_SIZE       = 16;
    localparam int NUM_GRP        = (CAPACITY + GRP_SIZE - 1) / GRP_SIZE;
    localparam int COMPACT_CYCLES = 2 * CAPACITY;
    localparam int CCNT_W         = $clog2(COMPACT_CYCLES + 1);
    localparam int KEY_W          = 8 + 32 + 32 + 1;

    localparam logic [31:0] POS_MASK = (POSITION_BITS >= 32) ? 32'hFFFF_FFFF :
                                       32'((64'd1 << POSITION_BITS) - 64'd1);
    localparam logic [15:0] QUALITY_FLOOR   = 16'd30;
    localparam logic [15:0] VALUE_MAX       = 16'hFFFF;

    // action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_FILTER = 2'd2;

    // status codes
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_MERGED   = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_FILTERED = 3'd5;

    // register indexes
    localparam logic [1:0] REG_PSEUDO   = 2'd0;
    localparam logic [1:0] REG_MIN_COV  = 2'd1;
    localparam logic [1:0] REG_MIN_QUAL = 2'd2;

    typedef struct packed {
        logic [7:0]  chrom;
        logic        minus;
        logic [31:0] start;
        logic [31:0] end_pos;
        logic        cons;
        logic [15:0] qual;
        logic [15:0] cov;
        logic [31:0] tag;
    } entry_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] idx;
        entry_t           ent;
    } sel_t;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_COMPARE,
        OP_UPDATE,
        OP_SEL_RANK,
        OP_MARK,
        OP_COMPACT,
        OP_SEL_LAST
    } cell_op_t;

    typedef struct packed {
        cell_op_t          op;
        entry_t            cand;
        logic              any_eq;
        logic              full;
        logic [RANK_W-1:0] rank;
        logic [15:0]       min_cov;
        logic [15:0]       min_qual;
    } cell_cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COMPARE,
        S_EQ_REDUCE,
        S_UPDATE,
        S_SEL_RANK,
        S_MARK,
        S_COMPACT,
        S_SEL_LAST,
        S_GATHER,
        S_FINISH
    } state_t;

    function automatic logic [KEY_W-1:0] key_of(input entry_t e);
        return {e.chrom, e.start, e.end_pos, e.minus};
    endfunction

endpackage

// File: hw/rtl/sjt_cell.sv
// ----------------------------------------------------------------------------
// sjt_cell: one slot of the sorted junction chain
// Holds one entry, compares it with the request key, shifts, merges, filters
// and compacts together with its two neighbors.
// ----------------------------------------------------------------------------
module sjt_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [sjt_pkg::IDX_W-1:0] cell_idx,
    input  sjt_pkg::cell_cmd_t       cmd,
    input  sjt_pkg::entry_t          prev_ent,
    input  logic                     prev_v,
    input  logic                     prev_place,
    input  sjt_pkg::entry_t          next_ent,
    input  logic                     next_v,
    output sjt_pkg::entry_t          ent,
    output logic                     v,
    output logic                     place,
    output logic                     eq,
    output sjt_pkg::sel_t            sel_out
);

    sjt_pkg::entry_t ent_reg, ent_next, merged;
    logic            v_reg, v_next;
    logic            lt_reg, lt_next;
    logic            eq_reg, eq_next;
    logic            sel_reg, sel_next;
    logic            first, keep;
    logic [16:0]     cov_sum;
    logic [16:0]     cov_twice;

    assign ent   = ent_reg;
    assign v     = v_reg;
    assign eq    = eq_reg;
    // first slot at or above the insertion point
    assign place = v_reg ? lt_reg : prev_v;
    assign first = place & ~prev_place;

    // drive the selected slot onto the gather tree
    always_comb
    begin
        sel_out     = '0;
        sel_out.hit = sel_reg;
        sel_out.idx = sel_reg ? cell_idx : '0;
        sel_out.ent = sel_reg ? ent_reg : '0;
    end

    // merge the request into this slot
    always_comb
    begin
        merged      = ent_reg;
        merged.cons = ent_reg.cons & cmd.cand.cons;
        if (cmd.cand.qual > ent_reg.qual)
        begin
            merged.qual = cmd.cand.qual;
            merged.tag  = cmd.cand.tag;
        end
        cov_sum = {1'b0, ent_reg.cov} + {1'b0, cmd.cand.cov};
        if (ent_reg.cov == 16'd0 || cmd.cand.cov == 16'd0)
            merged.cov = 16'd0;
        else if (cov_sum[16])
            merged.cov = sjt_pkg::VALUE_MAX;
        else
            merged.cov = cov_sum[15:0];
    end

    // filter thresholds
    always_comb
    begin
        cov_twice = {cmd.min_cov, 1'b0};
        keep = 1'b1;
        if (ent_reg.qual < cmd.min_qual)
            keep = 1'b0;
        if (ent_reg.cov < cmd.min_cov)
            keep = 1'b0;
        if (({1'b0, ent_reg.cov} < cov_twice || ent_reg.qual < sjt_pkg::QUALITY_FLOOR)
            && cmd.min_qual != 16'd0 && !ent_reg.cons)
            keep = 1'b0;
    end

    // next slot contents
    always_comb
    begin
        ent_next = ent_reg;
        v_next   = v_reg;
        lt_next  = lt_reg;
        eq_next  = eq_reg;
        sel_next = sel_reg;
        case (cmd.op)
            sjt_pkg::OP_COMPARE:
            begin
                lt_next  = sjt_pkg::key_of(cmd.cand) < sjt_pkg::key_of(ent_reg);
                eq_next  = v_reg && (sjt_pkg::key_of(cmd.cand) == sjt_pkg::key_of(ent_reg));
                sel_next = 1'b0;
            end
            sjt_pkg::OP_UPDATE:
            begin
                if (cmd.any_eq)
                begin
                    if (eq_reg)
                        ent_next = merged;
                    sel_next = eq_reg;
                end
                else
                begin
                    sel_next = first;
                    if (!cmd.full && place)
                    begin
                        ent_next = prev_place ? prev_ent : cmd.cand;
                        v_next   = 1'b1;
                    end
                end
            end
            sjt_pkg::OP_SEL_RANK:
            begin
                sel_next = v_reg &&
                           (sjt_pkg::SEL_W'(cell_idx) == sjt_pkg::SEL_W'(cmd.rank));
            end
            sjt_pkg::OP_MARK:
            begin
                v_next = v_reg & keep;
            end
            sjt_pkg::OP_COMPACT:
            begin
                // pull the upper neighbor into a hole, leave a hole behind
                if (!v_reg && next_v)
                begin
                    ent_next = next_ent;
                    v_next   = 1'b1;
                end
                else if (v_reg && !prev_v)
                begin
                    v_next = 1'b0;
                end
            end
            sjt_pkg::OP_SEL_LAST:
            begin
                sel_next = v_reg & ~next_v;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= 1'b0;
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
            sel_reg <= 1'b0;
        end
        else
        begin
            v_reg   <= v_next;
            lt_reg  <= lt_next;
            eq_reg  <= eq_next;
            sel_reg <= sel_next;
        end
    end

endmodule

// File: hw/rtl/sorted_junction_table.sv
// ----------------------------------------------------------------------------
// sorted_junction_table: sorted splice junction table with merge and filter
// A chain of slot cells keeps the entries in key order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_valid/in_ready channel: insert or merge, read at
//   rank, or filter and compact. Each request gives one result on the
//   out_valid/out_ready channel. Thresholds and the annotation value are set
//   through the APB port; the user must write them only while the block is
//   idle, as the block itself does not enforce this. An insert steps through
//   compare, match reduce, shift/merge, gather and finish; a read through rank
//   select, gather and finish; a filter through mark, a compaction sweep in
//   which each hole moves one slot per cycle, last-slot select, gather and
//   finish. One request is worked on at a time; the next can be accepted in
//   the cycle after its result is loaded.
//   The gather tree ORs the slots in groups of 16 in the gather step and the
//   registered group results in the finish step.
//   Reset empties the table at once through the slot valid bits; no
//   clearing pass is needed.
//   When the receiver stalls, the result waits in the output register, the
//   next request can still be accepted and worked on, and it waits in its
//   finish step until the output register frees up.
// ----------------------------------------------------------------------------
module sorted_junction_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  chromosome,
    input  logic        strand_minus,
    input  logic [31:0] intron_start,
    input  logic [31:0] intron_end,
    input  logic        is_consensus,
    input  logic signed [16:0] quality,
    input  logic signed [16:0] support,
    input  logic [31:0] read_tag,
    input  logic [7:0]  rank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [8:0]  position,
    output logic [7:0]  entry_chromosome,
    output logic        entry_strand_minus,
    output logic [31:0] entry_start,
    output logic [31:0] entry_end,
    output logic        entry_consensus,
    output logic [15:0] entry_quality,
    output logic [15:0] entry_coverage,
    output logic [31:0] entry_read_tag,
    output logic [8:0]  entry_count,
    output logic [8:0]  dropped_count
);

    // configuration registers
    logic [15:0] pseudo_reg, min_cov_reg, min_qual_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pseudo_reg   <= 16'd1;
            min_cov_reg  <= 16'd1;
            min_qual_reg <= 16'd0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                sjt_pkg::REG_PSEUDO:   pseudo_reg   <= pwdata[15:0];
                sjt_pkg::REG_MIN_COV:  min_cov_reg  <= pwdata[15:0];
                sjt_pkg::REG_MIN_QUAL: min_qual_reg <= pwdata[15:0];
                default:               pseudo_reg   <= pseudo_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (paddr[3:2])
            sjt_pkg::REG_PSEUDO:   prdata = {16'd0, pseudo_reg};
            sjt_pkg::REG_MIN_COV:  prdata = {16'd0, min_cov_reg};
            sjt_pkg::REG_MIN_QUAL: prdata = {16'd0, min_qual_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // control and request registers
    sjt_pkg::state_t    state_reg, state_next;
    logic [1:0]         act_reg;
    sjt_pkg::entry_t    cand_reg;
    logic [7:0]         rank_reg;
    logic [sjt_pkg::CNT_W-1:0]  count_reg;
    logic [sjt_pkg::CCNT_W-1:0] ccnt_reg;
    logic               any_eq_reg;
    logic               full_reg;
    logic [sjt_pkg::NUM_GRP-1:0] eqgrp_reg;
    sjt_pkg::sel_t      grp_reg [sjt_pkg::NUM_GRP];
    sjt_pkg::cell_cmd_t cmd;
    logic               in_acc, load_out;
    logic               full;

    // output registers
    logic               out_valid_reg;
    logic [2:0]         status_reg;
    logic [8:0]         position_reg, count_out_reg, dropped_reg;
    sjt_pkg::entry_t    out_ent_reg;

    assign in_acc = in_valid & in_ready;
    assign full   = (count_reg == sjt_pkg::CNT_W'(sjt_pkg::CAPACITY));

    // slot chain
    sjt_pkg::entry_t cell_ent   [sjt_pkg::CAPACITY];
    logic            cell_v     [sjt_pkg::CAPACITY];
    logic            cell_place [sjt_pkg::CAPACITY];
    logic            cell_eq    [sjt_pkg::CAPACITY];
    sjt_pkg::sel_t   cell_sel   [sjt_pkg::CAPACITY];

    for (genvar i = 0; i < sjt_pkg::CAPACITY; i++)
    begin : g_cell
        sjt_pkg::entry_t prev_ent, next_ent;
        logic            prev_v, prev_place, next_v;

        if (i == 0)
        begin : g_head
            assign prev_ent   = '0;
            assign prev_v     = 1'b1;
            assign prev_place = 1'b0;
        end
        else
        begin : g_body
            assign prev_ent   = cell_ent[i-1];
            assign prev_v     = cell_v[i-1];
            assign prev_place = cell_place[i-1];
        end

        if (i == sjt_pkg::CAPACITY - 1)
        begin : g_tail
            assign next_ent = '0;
            assign next_v   = 1'b0;
        end
        else
        begin : g_mid
            assign next_ent = cell_ent[i+1];
            assign next_v   = cell_v[i+1];
        end

        sjt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (sjt_pkg::IDX_W'(i)),
            .cmd        (cmd),
            .prev_ent   (prev_ent),
            .prev_v     (prev_v),
            .prev_place (prev_place),
            .next_ent   (next_ent),
            .next_v     (next_v),
            .ent        (cell_ent[i]),
            .v          (cell_v[i]),
            .place      (cell_place[i]),
            .eq         (cell_eq[i]),
            .sel_out    (cell_sel[i])
        );
    end

    // first level of the gather and match trees
    sjt_pkg::sel_t grp_or [sjt_pkg::NUM_GRP];
    logic [sjt_pkg::NUM_GRP-1:0] grp_eq;

    for (genvar g = 0; g < sjt_pkg::NUM_GRP; g++)
    begin : g_grp
        always_comb
        begin
            grp_or[g] = '0;
            grp_eq[g] = 1'b0;
            for (int k = 0; k < sjt_pkg::GRP_SIZE; k++)
            begin
                if (g * sjt_pkg::GRP_SIZE + k < sjt_pkg::CAPACITY)
                begin
                    grp_or[g] = sjt_pkg::sel_t'(grp_or[g] | cell_sel[g * sjt_pkg::GRP_SIZE + k]);
                    grp_eq[g] = grp_eq[g] | cell_eq[g * sjt_pkg::GRP_SIZE + k];
                end
            end
        end
    end

    // second level of the gather tree
    sjt_pkg::sel_t fin;
    always_comb
    begin
        fin = '0;
        for (int g = 0; g < sjt_pkg::NUM_GRP; g++)
            fin = sjt_pkg::sel_t'(fin | grp_reg[g]);
    end

    // next state and cell command
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        load_out     = 1'b0;
        cmd          = '0;
        cmd.op       = sjt_pkg::OP_HOLD;
        cmd.cand     = cand_reg;
        cmd.rank     = rank_reg;
        cmd.min_cov  = min_cov_reg;
        cmd.min_qual = min_qual_reg;
        cmd.any_eq   = |eqgrp_reg;
        cmd.full     = full;
        unique case (state_reg)
            sjt_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (action == sjt_pkg::ACT_INSERT)
                        state_next = sjt_pkg::S_COMPARE;
                    else if (action == sjt_pkg::ACT_FILTER)
                        state_next = sjt_pkg::S_MARK;
                    else
                        state_next = sjt_pkg::S_SEL_RANK;
                end
            end
            sjt_pkg::S_COMPARE:
            begin
                cmd.op     = sjt_pkg::OP_COMPARE;
                state_next = sjt_pkg::S_EQ_REDUCE;
            end
            sjt_pkg::S_EQ_REDUCE:
            begin
                state_next = sjt_pkg::S_UPDATE;
            end
            sjt_pkg::S_UPDATE:
            begin
                cmd.op     = sjt_pkg::OP_UPDATE;
                state_next = sjt_pkg::S_GATHER;
            end
            sjt_pkg::S_SEL_RANK:
            begin
                cmd.op     = sjt_pkg::OP_SEL_RANK;
                state_next = sjt_pkg::S_GATHER;
            end
            sjt_pkg::S_MARK:
            begin
                cmd.op     = sjt_pkg::OP_MARK;
                state_next = sjt_pkg::S_COMPACT;
            end
            sjt_pkg::S_COMPACT:
            begin
                cmd.op = sjt_pkg::OP_COMPACT;
                if (ccnt_reg == sjt_pkg::CCNT_W'(sjt_pkg::COMPACT_CYCLES - 1))
                    state_next = sjt_pkg::S_SEL_LAST;
            end
            sjt_pkg::S_SEL_LAST:
            begin
                cmd.op     = sjt_pkg::OP_SEL_LAST;
                state_next = sjt_pkg::S_GATHER;
            end
            sjt_pkg::S_GATHER:
            begin
                state_next = sjt_pkg::S_FINISH;
            end
            sjt_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    load_out   = 1'b1;
                    state_next = sjt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sjt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sjt_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

    // latch the request, replacing annotation values
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg          <= action;
            rank_reg         <= rank;
            cand_reg.chrom   <= chromosome;
            cand_reg.minus   <= strand_minus;
            cand_reg.start   <= intron_start & sjt_pkg::POS_MASK;
            cand_reg.end_pos <= intron_end & sjt_pkg::POS_MASK;
            cand_reg.cons    <= is_consensus;
            cand_reg.qual    <= quality[16] ? pseudo_reg : quality[15:0];
            cand_reg.cov     <= support[16] ? pseudo_reg : support[15:0];
            cand_reg.tag     <= read_tag;
        end
        if (state_reg == sjt_pkg::S_EQ_REDUCE)
            eqgrp_reg <= grp_eq;
        // hold the match and fill flags as seen by the shift step
        if (state_reg == sjt_pkg::S_UPDATE)
        begin
            any_eq_reg <= |eqgrp_reg;
            full_reg   <= full;
        end
        if (state_reg == sjt_pkg::S_GATHER)
            grp_reg <= grp_or;
    end

    // table fill and compaction counters
    logic [sjt_pkg::CNT_W-1:0] kept;
    assign kept = fin.hit ? (sjt_pkg::CNT_W'(fin.idx) + sjt_pkg::CNT_W'(1)) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ccnt_reg  <= '0;
        end
        else
        begin
            if (state_reg == sjt_pkg::S_UPDATE && !(|eqgrp_reg) && !full)
                count_reg <= count_reg + sjt_pkg::CNT_W'(1);
            if (load_out && act_reg == sjt_pkg::ACT_FILTER)
                count_reg <= kept;
            if (state_reg == sjt_pkg::S_COMPACT)
                ccnt_reg <= ccnt_reg + sjt_pkg::CCNT_W'(1);
            else
                ccnt_reg <= '0;
        end
    end

    // build the result
    logic [2:0]      status_next;
    logic [8:0]      position_next, count_out_next, dropped_next;
    sjt_pkg::entry_t out_ent_next;

    always_comb
    begin
        status_next    = sjt_pkg::ST_INSERTED;
        out_ent_next   = '0;
        position_next  = '0;
        dropped_next   = '0;
        count_out_next = 9'(count_reg);
        if (act_reg == sjt_pkg::ACT_INSERT)
        begin
            position_next = 9'(fin.idx);
            out_ent_next  = fin.ent;
            if (any_eq_reg)
                status_next = sjt_pkg::ST_MERGED;
            else if (full_reg)
            begin
                // refused entry; past the last slot when no slot ranks above it
                status_next  = sjt_pkg::ST_FULL;
                out_ent_next = cand_reg;
                if (!fin.hit)
                    position_next = 9'(sjt_pkg::CAPACITY);
            end
            else
                status_next = sjt_pkg::ST_INSERTED;
        end
        else if (act_reg == sjt_pkg::ACT_FILTER)
        begin
            status_next    = sjt_pkg::ST_FILTERED;
            count_out_next = 9'(kept);
            dropped_next   = 9'(count_reg - kept);
        end
        else
        begin
            position_next = 9'(rank_reg);
            if (fin.hit)
            begin
                status_next  = sjt_pkg::ST_READ_OK;
                out_ent_next = fin.ent;
            end
            else
                status_next = sjt_pkg::ST_EMPTY;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            status_reg    <= status_next;
            out_ent_reg   <= out_ent_next;
            position_reg  <= position_next;
            dropped_reg   <= dropped_next;
            count_out_reg <= count_out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign position           = position_reg;
    assign entry_chromosome   = out_ent_reg.chrom;
    assign entry_strand_minus = out_ent_reg.minus;
    assign entry_start        = out_ent_reg.start;
    assign entry_end          = out_ent_reg.end_pos;
    assign entry_consensus    = out_ent_reg.cons;
    assign entry_quality      = out_ent_reg.qual;
    assign entry_coverage     = out_ent_reg.cov;
    assign entry_read_tag     = out_ent_reg.tag;
    assign entry_count        = count_out_reg;
    assign dropped_count      = dropped_reg;

endmodule

// File: hw/rtl/sjt_checker.sv
// ----------------------------------------------------------------------------
// sjt_checker: port-level checks of the sorted junction table
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module sjt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  status,
    input logic [8:0]  position,
    input logic [31:0] entry_start,
    input logic [15:0] entry_coverage,
    input logic [8:0]  entry_count
);

    // hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    // table never reports more entries than its capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> entry_count <= 9'(sjt_pkg::CAPACITY))
        else $error("entry count beyond capacity");

    // filter result carries no entry
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sjt_pkg::ST_FILTERED |-> position == 9'd0 &&
        entry_start == 32'd0 && entry_coverage == 16'd0)
        else $error("filter result carries entry data");

    // empty rank lies beyond the table
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == sjt_pkg::ST_EMPTY |-> position >= entry_count &&
        entry_coverage == 16'd0)
        else $error("empty read inside the table");

endmodule

bind sorted_junction_table sjt_checker u_sjt_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .position       (position),
    .entry_start    (entry_start),
    .entry_coverage (entry_coverage),
    .entry_count    (entry_count)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sorted junction table
// Drives insert, read and filter requests with random gaps, predicts each
// result from a behavioral copy of the table and compares every output field.
// ----------------------------------------------------------------------------
module tb;

    typedef struct {
        logic [1:0]  act;
        logic [7:0]  chrom;
        logic        minus;
        logic [31:0] start;
        logic [31:0] end_pos;
        logic        cons;
        logic [16:0] qual;
        logic [16:0] supp;
        logic [31:0] tag;
        logic [7:0]  rnk;
    } request_t;

    typedef struct {
        logic [2:0]       st;
        logic [8:0]       pos;
        sjt_pkg::entry_t  ent;
        logic [8:0]       cnt;
        logic [8:0]       drop;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid, in_ready;
    logic [1:0]  action;
    logic [7:0]  chromosome;
    logic        strand_minus;
    logic [31:0] intron_start, intron_end;
    logic        is_consensus;
    logic signed [16:0] quality, support;
    logic [31:0] read_tag;
    logic [7:0]  rank;
    logic        out_valid, out_ready;
    logic [2:0]  status;
    logic [8:0]  position;
    logic [7:0]  entry_chromosome;
    logic        entry_strand_minus;
    logic [31:0] entry_start, entry_end;
    logic        entry_consensus;
    logic [15:0] entry_quality, entry_coverage;
    logic [31:0] entry_read_tag;
    logic [8:0]  entry_count, dropped_count;

    sorted_junction_table dut (.*);

    // predictor state
    sjt_pkg::entry_t junctions [sjt_pkg::CAPACITY];
    int          junction_total;
    logic [15:0] pseudo_val, min_cov_val, min_qual_val;

    request_t    pending_requests [$];
    result_t     expected_results [$];
    int          mismatches;
    int          results_seen;
    int          sent_count;
    int          hold_off;
    logic        stalling;
    event        stall_start;
    int          send_gap, recv_gap;
    int          merges_seen, fulls_seen, filters_seen;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("** sorted_junction_table: FAILED **");
        $finish;
    end

    function automatic void add_pending(request_t rq);
        pending_requests.insert(pending_requests.size(), rq);
    endfunction

    function automatic void add_expected(result_t r);
        expected_results.insert(expected_results.size(), r);
    endfunction

    function automatic logic [15:0] annot_value(logic [16:0] raw);
        return raw[16] ? pseudo_val : raw[15:0];
    endfunction

    function automatic int key_order(sjt_pkg::entry_t a, sjt_pkg::entry_t b);
        if (sjt_pkg::key_of(a) < sjt_pkg::key_of(b))
            return -1;
        if (sjt_pkg::key_of(a) > sjt_pkg::key_of(b))
            return 1;
        return 0;
    endfunction

    // compute the result of one request and advance the table copy
    function automatic result_t table_step(request_t rq);
        result_t r;
        sjt_pkg::entry_t c;
        int      p;
        int      cmp;
        int      kept;
        int      dropped;
        logic    keep;
        logic [16:0] sum;
        r = '{default: '0};
        r.ent = '0;
        if (rq.act == sjt_pkg::ACT_INSERT)
        begin
            c.chrom   = rq.chrom;
            c.minus   = rq.minus;
            c.start   = rq.start & sjt_pkg::POS_MASK;
            c.end_pos = rq.end_pos & sjt_pkg::POS_MASK;
            c.cons    = rq.cons;
            c.qual    = annot_value(rq.qual);
            c.cov     = annot_value(rq.supp);
            c.tag     = rq.tag;
            p = 0;
            cmp = 1;
            while (p < junction_total)
            begin
                cmp = key_order(c, junctions[p]);
                if (cmp <= 0)
                    break;
                p++;
            end
            if (p < junction_total && cmp == 0)
            begin
                junctions[p].cons &= c.cons;
                if (c.qual > junctions[p].qual)
                begin
                    junctions[p].qual = c.qual;
                    junctions[p].tag  = c.tag;
                end
                if (junctions[p].cov != 0 && c.cov != 0)
                begin
                    sum = junctions[p].cov + c.cov;
                    junctions[p].cov = sum[16] ? sjt_pkg::VALUE_MAX : sum[15:0];
                end
                else
                    junctions[p].cov = '0;
                r.st  = sjt_pkg::ST_MERGED;
                r.ent = junctions[p];
            end
            else if (junction_total >= sjt_pkg::CAPACITY)
            begin
                r.st  = sjt_pkg::ST_FULL;
                r.ent = c;
            end
            else
            begin
                for (int i = junction_total; i > p; i--)
                    junctions[i] = junctions[i-1];
                junctions[p] = c;
                junction_total++;
                r.st  = sjt_pkg::ST_INSERTED;
                r.ent = c;
            end
            r.pos = 9'(p);
            r.cnt = 9'(junction_total);
        end
        else if (rq.act == sjt_pkg::ACT_FILTER)
        begin
            kept = 0;
            dropped = 0;
            for (int i = 0; i < junction_total; i++)
            begin
                keep = 1'b1;
                if (junctions[i].qual < min_qual_val)
                    keep = 1'b0;
                if (junctions[i].cov < min_cov_val)
                    keep = 1'b0;
                if ((32'(junctions[i].cov) < 2 * 32'(min_cov_val)
                     || junctions[i].qual < sjt_pkg::QUALITY_FLOOR)
                    && min_qual_val != 0 && !junctions[i].cons)
                    keep = 1'b0;
                if (keep)
                begin
                    junctions[kept] = junctions[i];
                    kept++;
                end
                else
                    dropped++;
            end
            junction_total = kept;
            r.st   = sjt_pkg::ST_FILTERED;
            r.cnt  = 9'(kept);
            r.drop = 9'(dropped);
        end
        else
        begin
            // read; the unused action code behaves the same way
            r.pos = 9'(rq.rnk);
            if (rq.rnk < junction_total)
            begin
                r.st  = sjt_pkg::ST_READ_OK;
                r.ent = junctions[rq.rnk];
            end
            else
                r.st = sjt_pkg::ST_EMPTY;
            r.cnt = 9'(junction_total);
        end
        return r;
    endfunction

    // driver: present queued requests with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_valid && !in_ready)
        begin
            // hold the request
        end
        else
        begin
            if (in_valid)
            begin
                add_expected(table_step(pending_requests.pop_front()));
                sent_count++;
            end
            if (send_gap > 0 || pending_requests.size() == 0)
            begin
                in_valid <= 1'b0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                request_t nx;
                nx = pending_requests[0];
                in_valid     <= 1'b1;
                action       <= nx.act;
                chromosome   <= nx.chrom;
                strand_minus <= nx.minus;
                intron_start <= nx.start;
                intron_end   <= nx.end_pos;
                is_consensus <= nx.cons;
                quality      <= nx.qual;
                support      <= nx.supp;
                read_tag     <= nx.tag;
                rank         <= nx.rnk;
                send_gap     <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // long receiver stall, counted in cycles
    initial
    begin
        stalling = 1'b0;
        hold_off = 0;
        forever
        begin
            @(stall_start);
            stalling <= 1'b1;
            for (hold_off = 300; hold_off > 0; hold_off--)
                @(posedge clk);
            stalling <= 1'b0;
        end
    end

    // monitor: accept results, stall at random, compare against predictions
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_t e;
                result_t a;
                a.st = status;
                a.pos = position;
                a.ent.chrom   = entry_chromosome;
                a.ent.minus   = entry_strand_minus;
                a.ent.start   = entry_start;
                a.ent.end_pos = entry_end;
                a.ent.cons    = entry_consensus;
                a.ent.qual    = entry_quality;
                a.ent.cov     = entry_coverage;
                a.ent.tag     = entry_read_tag;
                a.cnt  = entry_count;
                a.drop = dropped_count;
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: status %0d", status);
                end
                else
                begin
                    e = expected_results.pop_front();
                    if (e.st == sjt_pkg::ST_MERGED)
                        merges_seen++;
                    if (e.st == sjt_pkg::ST_FULL)
                        fulls_seen++;
                    if (e.st == sjt_pkg::ST_FILTERED)
                        filters_seen++;
                    if (a.st !== e.st || a.pos !== e.pos || a.ent !== e.ent
                        || a.cnt !== e.cnt || a.drop !== e.drop)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("result %0d mismatch: exp st%0d pos%0d ent %h cnt%0d drop%0d",
                                     results_seen, e.st, e.pos, e.ent, e.cnt, e.drop);
                            $display("    got st%0d pos%0d ent %h cnt%0d drop%0d",
                                     a.st, a.pos, a.ent, a.cnt, a.drop);
                        end
                    end
                end
            end
            if (stalling)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap  <= recv_gap - 1;
            end
            else
            begin
                out_ready <= 1'b1;
                if (out_valid && out_ready)
                    recv_gap <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
            end
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sjt_pkg::REG_PSEUDO:   pseudo_val   = val;
            sjt_pkg::REG_MIN_COV:  min_cov_val  = val;
            sjt_pkg::REG_MIN_QUAL: min_qual_val = val;
            default: ;
        endcase
    endtask

    task automatic queue_request(logic [1:0] act, logic [7:0] chrom, logic minus,
                                 logic [31:0] st, logic [31:0] en, logic cons,
                                 logic [16:0] q, logic [16:0] s, logic [7:0] rk);
        request_t rq;
        rq.act = act;  rq.chrom = chrom; rq.minus = minus;
        rq.start = st; rq.end_pos = en;  rq.cons = cons;
        rq.qual = q;   rq.supp = s;      rq.tag = $urandom;
        rq.rnk = rk;
        add_pending(rq);
    endtask

    // random request; narrow keys share a small pool so merges happen often
    task automatic queue_random_request(int wide_keys);
        int       k;
        logic [16:0] q, s;
        k = $urandom_range(0, 99);
        q = ($urandom_range(0, 9) == 0) ? 17'h1FFFF :
            (($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 65535)) :
                                           17'($urandom_range(0, 60)));
        s = ($urandom_range(0, 9) == 0) ? 17'h1FFFF :
            (($urandom_range(0, 7) == 0) ? 17'($urandom_range(0, 65535)) :
                                           17'($urandom_range(0, 5)));
        if (k < 70)
            queue_request(sjt_pkg::ACT_INSERT,
                          wide_keys ? 8'($urandom) : 8'($urandom_range(0, 3)),
                          1'($urandom_range(0, 1)),
                          wide_keys ? $urandom : 32'($urandom_range(0, 7)),
                          wide_keys ? $urandom : 32'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), q, s, 8'($urandom));
        else if (k < 96)
            queue_request((k < 93) ? sjt_pkg::ACT_READ : 2'd3, 8'($urandom), 1'($urandom),
                          $urandom, $urandom, 1'($urandom), 17'($urandom),
                          17'($urandom), ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                          8'($urandom_range(0, 40)));
        else
            queue_request(sjt_pkg::ACT_FILTER, 8'($urandom), 1'($urandom), $urandom,
                          $urandom, 1'($urandom), 17'($urandom), 17'($urandom),
                          8'($urandom));
    endtask

    task automatic drain();
        while (pending_requests.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (2 * sjt_pkg::CAPACITY + 20) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0; out_ready = 1'b0;
        action = '0; chromosome = '0; strand_minus = 1'b0; intron_start = '0;
        intron_end = '0; is_consensus = 1'b0; quality = '0; support = '0;
        read_tag = '0; rank = '0;
        junction_total = 0;
        pseudo_val = 16'd1; min_cov_val = 16'd1; min_qual_val = 16'd0;
        mismatches = 0; results_seen = 0; sent_count = 0;
        merges_seen = 0; fulls_seen = 0; filters_seen = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: empty table, field extremes, merges, annotation values
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(sjt_pkg::ACT_FILTER, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(sjt_pkg::ACT_INSERT, 8'hFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                      17'h0FFFF, 17'h0FFFF, 0);
        queue_request(sjt_pkg::ACT_INSERT, 8'hFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0,
                      17'd40, 17'd5, 0);
        queue_request(sjt_pkg::ACT_INSERT, 0, 1, 0, 0, 1, 17'h1FFFF, 17'h1FFFF, 0);
        queue_request(sjt_pkg::ACT_INSERT, 0, 0, 0, 0, 1, 17'd35, 17'd0, 0);
        queue_request(sjt_pkg::ACT_INSERT, 0, 0, 0, 0, 0, 17'd50, 17'd3, 0);
        queue_request(sjt_pkg::ACT_INSERT, 0, 0, 0, 1, 1, 17'd10, 17'd2, 0);
        queue_request(sjt_pkg::ACT_INSERT, 0, 0, 1, 0, 0, 17'd31, 17'd9, 0);
        queue_request(sjt_pkg::ACT_INSERT, 1, 0, 0, 0, 1, 17'h10000, 17'h10005, 0);
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 3);
        queue_request(2'd3, 0, 0, 0, 0, 0, 0, 0, 6);
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 8'hFF);
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 7);
        queue_request(sjt_pkg::ACT_FILTER, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(sjt_pkg::ACT_READ, 0, 0, 0, 0, 0, 0, 0, 1);
        drain();

        // stricter filter settings and a large annotation value
        reg_write(sjt_pkg::REG_PSEUDO, 16'hFFFF);
        reg_write(sjt_pkg::REG_MIN_COV, 16'd2);
        reg_write(sjt_pkg::REG_MIN_QUAL, 16'd20);
        for (int i = 0; i < 100; i++)
            queue_random_request(0);
        queue_request(sjt_pkg::ACT_FILTER, 0, 0, 0, 0, 0, 0, 0, 0);
        // long receiver stall while requests keep coming
        -> stall_start;
        drain();

        // extremes: thresholds at maximum, then at zero
        reg_write(sjt_pkg::REG_MIN_COV, 16'hFFFF);
        reg_write(sjt_pkg::REG_MIN_QUAL, 16'hFFFF);
        for (int i = 0; i < 100; i++)
            queue_random_request(0);
        drain();
        reg_write(sjt_pkg::REG_PSEUDO, 16'd0);
        reg_write(sjt_pkg::REG_MIN_COV, 16'd0);
        reg_write(sjt_pkg::REG_MIN_QUAL, 16'd0);

        // fill the table to capacity with distinct keys, then overflow it
        for (int i = 0; i < sjt_pkg::CAPACITY + 20; i++)
            queue_request(sjt_pkg::ACT_INSERT, 8'($urandom), 1'($urandom), $urandom,
                          $urandom, 1'($urandom), 17'($urandom_range(0, 100)),
                          17'($urandom_range(1, 9)), 0);
        for (int i = 0; i < 50; i++)
            queue_random_request(1);
        drain();
        reg_write(sjt_pkg::REG_MIN_COV, 16'd3);
        reg_write(sjt_pkg::REG_MIN_QUAL, 16'd1);
        queue_request(sjt_pkg::ACT_FILTER, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 50; i++)
            queue_random_request(0);
        drain();

        $display("covered %0d requests: %0d merges, %0d table-full drops, %0d filters",
                 sent_count, merges_seen, fulls_seen, filters_seen);
        $display("register settings swept through zero and full-scale thresholds");
        if (mismatches == 0 && expected_results.size() == 0)
            $display("** sorted_junction_table: PASSED **");
        else
        begin
            $display("%0d mismatches", mismatches);
            $display("** sorted_junction_table: FAILED **");
        end
        $finish;
    end

endmodule

// File: sorted_junction_table.f
hw/rtl/sjt_pkg.sv
hw/rtl/sjt_cell.sv
hw/rtl/sorted_junction_table.sv
hw/rtl/sjt_checker.sv
tb/tb.sv
